// File: hw/rtl/rast_pkg.sv
// ----------------------------------------------------------------------------
// rast_pkg
// Shared types, constants and helpers of the range affine sum tree.
// ----------------------------------------------------------------------------
package rast_pkg;

    localparam int unsigned OPC_W    = 2;
    localparam int unsigned POS_IN_W = 11;
    localparam int unsigned VAL_W    = 30;

    localparam int unsigned DEF_MAX_ELEMENTS = 1024;

    // prime modulus and Barrett constant floor(2^60 / p)
    localparam logic [31:0] MOD_P  = 32'd1000000007;
    localparam logic [63:0] MOD_MU = (64'd1 << 60) / {32'd0, MOD_P};

    typedef enum logic [OPC_W-1:0] {
        OP_ADD   = 2'd0,
        OP_MUL   = 2'd1,
        OP_SET   = 2'd2,
        OP_QUERY = 2'd3
    } t_opcode;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_VISIT,
        S_NODE,
        S_AP_RD,
        S_AP_LD,
        S_AP_GO,
        S_AP_WAIT,
        S_AP_WR,
        S_PUSH_R,
        S_TAGCLR,
        S_DOWN,
        S_RET,
        S_CB_RDL,
        S_CB_RDR,
        S_CB_SUM,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        AK_COVER,
        AK_LEFT,
        AK_RIGHT
    } t_apply_kind;

    typedef enum logic [1:0] {
        AP_LEN,
        AP_SUM,
        AP_SCALE,
        AP_OFFSET
    } t_ap_step;

    typedef enum logic [2:0] {
        MM_IDLE,
        MM_RED_Q,
        MM_RED_QP,
        MM_RED_SUB,
        MM_FIX1,
        MM_FIX2,
        MM_DONE
    } t_mm_state;

    // modular multiply-add request: (x * y + z) mod p, all operands below p
    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] x;
        logic [VAL_W-1:0] y;
        logic [VAL_W-1:0] z;
    } t_mm_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] res;
    } t_mm_rsp;

    function automatic logic [VAL_W-1:0] add_mod(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= MOD_P[VAL_W:0]) begin
            s = s - MOD_P[VAL_W:0];
        end
        return s[VAL_W-1:0];
    endfunction

endpackage

// File: hw/rtl/rast_chan_if.sv
// ----------------------------------------------------------------------------
// rast channel interfaces
// Request, response and length configuration channels, valid/ready.
// ----------------------------------------------------------------------------
interface rast_req_if;
    logic                           valid;
    logic                           ready;
    logic [rast_pkg::OPC_W-1:0]     opcode;
    logic [rast_pkg::POS_IN_W-1:0]  left;
    logic [rast_pkg::POS_IN_W-1:0]  right;
    logic [rast_pkg::VAL_W-1:0]     value;

    modport source (output valid, output opcode, output left, output right,
                    output value, input ready);
    modport sink   (input valid, input opcode, input left, input right,
                    input value, output ready);
endinterface

interface rast_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [rast_pkg::VAL_W-1:0] range_sum;

    modport source (output valid, output range_sum, input ready);
    modport sink   (input valid, input range_sum, output ready);
endinterface

interface rast_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rast_pkg::POS_IN_W-1:0] length_in_use;

    modport source (output valid, output length_in_use, input ready);
    modport sink   (input valid, input length_in_use, output ready);
endinterface

// File: hw/rtl/rast_ram.sv
// ----------------------------------------------------------------------------
// rast_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rast_ram #(
    parameter int unsigned WIDTH = 30,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/rast_mulmod.sv
// ----------------------------------------------------------------------------
// rast_mulmod
// Shared modular multiply-add: one 32x32 multiplier, Barrett reduction.
// ----------------------------------------------------------------------------
module rast_mulmod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rast_pkg::t_mm_req i_req,
    output rast_pkg::t_mm_rsp o_rsp
);
    import rast_pkg::*;

    t_mm_state   r_state, n_state;
    logic [59:0] r_t;
    logic [30:0] r_q;
    logic [31:0] r_qp;
    logic [31:0] r_r;
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    logic [31:0] w_fix;

    assign w_prod = w_ma * w_mb;
    assign w_fix  = (r_r >= MOD_P) ? r_r - MOD_P : r_r;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            MM_IDLE:    if (i_req.start) n_state = MM_RED_Q;
            MM_RED_Q:   n_state = MM_RED_QP;
            MM_RED_QP:  n_state = MM_RED_SUB;
            MM_RED_SUB: n_state = MM_FIX1;
            MM_FIX1:    n_state = MM_FIX2;
            MM_FIX2:    n_state = MM_DONE;
            MM_DONE:    n_state = MM_IDLE;
            default:    n_state = MM_IDLE;
        endcase
    end

    // operand selection of the shared multiplier
    always_comb begin
        w_ma = {2'b00, i_req.x};
        w_mb = {2'b00, i_req.y};
        unique case (r_state)
            MM_RED_Q: begin
                w_ma = {1'b0, r_t[59:29]};
                w_mb = MOD_MU[31:0];
            end
            MM_RED_QP: begin
                w_ma = {1'b0, r_q};
                w_mb = MOD_P;
            end
            default: begin
                w_ma = {2'b00, i_req.x};
                w_mb = {2'b00, i_req.y};
            end
        endcase
        o_rsp.done = (r_state == MM_DONE);
        o_rsp.res  = r_r[VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            MM_IDLE:    r_t  <= w_prod[59:0] + {30'd0, i_req.z};
            MM_RED_Q:   r_q  <= w_prod[61:31];
            MM_RED_QP:  r_qp <= w_prod[31:0];
            MM_RED_SUB: r_r  <= r_t[31:0] - r_qp;
            MM_FIX1:    r_r  <= w_fix;
            MM_FIX2:    r_r  <= w_fix;
            default:    r_r  <= r_r;
        endcase
    end
endmodule

// File: hw/rtl/range_affine_sum_tree_unit.sv
// ----------------------------------------------------------------------------
// range_affine_sum_tree_unit
// Lazy segment tree over values modulo 1000000007: range add, multiply,
// set and range sum query.
// ----------------------------------------------------------------------------
// The block keeps positions 1..length_in_use in a heap-numbered segment tree
// of 2*MAX_ELEMENTS nodes, each node holding a sum and a pending affine tag
// (scale, offset) in three RAMs. A request walks the tree depth first under a
// small sequencer with an explicit stack; one request is worked at a time and
// i_req.ready is low until the walk ends. A tag application fetches the node,
// runs four modular multiply-adds (two at a leaf) through the single shared
// multiplier-reducer and writes the node back; a partially covered node is
// recombined from its children on the way up. A wide update pays at most about
// six tag applications per tree level (up to two covered nodes plus the pushes
// from up to two partially covered nodes), some sixty for 1024 positions.
// After reset a clearing pass over all 2*MAX_ELEMENTS nodes initialises the
// store (sums zero, tags identity) before the first request is taken; length
// writes are accepted throughout. A finished query sum waits in an output
// register, so the next request may be taken while it is still unclaimed.
// ----------------------------------------------------------------------------
module range_affine_sum_tree_unit #(
    parameter int unsigned MAX_ELEMENTS = rast_pkg::DEF_MAX_ELEMENTS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rast_cfg_if.sink   i_cfg,
    rast_req_if.sink   i_req,
    rast_rsp_if.source o_resp
);
    import rast_pkg::*;

    localparam int unsigned TN     = 2 * MAX_ELEMENTS;
    localparam int unsigned AW     = $clog2(TN);
    localparam int unsigned NODE_W = AW + 1;
    localparam int unsigned POS_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int unsigned CW     = (POS_W > POS_IN_W) ? POS_W : POS_IN_W;
    localparam int unsigned STK_D  = $clog2(MAX_ELEMENTS) + 1;
    localparam int unsigned SP_W   = $clog2(STK_D + 1);
    localparam int unsigned SI_W   = $clog2(STK_D);

    // control
    t_state             r_state, n_state;
    logic [SP_W-1:0]    r_sp;
    logic [AW-1:0]      r_clr;
    logic [POS_W-1:0]   r_len;
    logic               r_out_valid;
    logic [VAL_W-1:0]   r_out_sum;

    // request and walk state
    t_opcode            r_op;
    logic [CW-1:0]      r_s, r_f;
    logic [VAL_W-1:0]   r_opa, r_opb;
    logic [NODE_W-1:0]  r_node;
    logic [POS_W-1:0]   r_lo, r_hi;
    logic [POS_W-1:0]   r_stk_lo [STK_D];
    logic [POS_W-1:0]   r_stk_hi [STK_D];
    logic [VAL_W-1:0]   r_acc;

    // tag application working set
    t_apply_kind        r_kind;
    t_ap_step           r_step;
    logic [NODE_W-1:0]  r_tnode;
    logic [POS_W-1:0]   r_tlo, r_thi;
    logic [VAL_W-1:0]   r_ca, r_cb;
    logic [VAL_W-1:0]   r_ws, r_wsc, r_wof, r_tmp;

    // RAM ports
    logic [AW-1:0]      w_raddr, w_waddr;
    logic               w_we_sum, w_we_tag;
    logic [VAL_W-1:0]   w_wd_sum, w_wd_scale, w_wd_off;
    logic [VAL_W-1:0]   w_rd_sum, w_rd_scale, w_rd_off;

    t_mm_req            w_mm_req;
    t_mm_rsp            w_mm_rsp;

    // walk helpers
    logic               w_accept, w_absent, w_disj, w_cover, w_ident, w_leaf;
    logic               w_left_ok, w_right_ok, w_out_load;
    logic [CW-1:0]      w_lo_c, w_hi_c;
    logic [POS_W:0]     w_lh, w_plh;
    logic [POS_W-1:0]   w_mid, w_pmid, w_plo, w_phi, w_tlen;
    logic [NODE_W-1:0]  w_left, w_right;
    logic [SP_W-1:0]    w_top;
    logic [31:0]        w_v32, w_cfg32, w_len32;
    logic [VAL_W-1:0]   w_vred, w_csum;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_lo_c     = CW'(r_lo);
    assign w_hi_c     = CW'(r_hi);
    assign w_absent   = r_node >= NODE_W'(TN);
    assign w_disj     = (r_f < w_lo_c) || (w_hi_c < r_s);
    assign w_cover    = (r_s <= w_lo_c) && (w_hi_c <= r_f);
    assign w_ident    = (w_rd_scale == 30'd1) && (w_rd_off == 30'd0);
    assign w_lh       = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_lh[POS_W:1];
    assign w_left     = {r_node[NODE_W-2:0], 1'b0};
    assign w_right    = {r_node[NODE_W-2:0], 1'b1};
    assign w_left_ok  = w_left < NODE_W'(TN);
    assign w_right_ok = w_right < NODE_W'(TN);
    assign w_leaf     = (r_tlo == r_thi);
    assign w_tlen     = r_thi - r_tlo + 1'b1;

    // parent frame sits on top of the stack
    assign w_top  = r_sp - 1'b1;
    assign w_plo  = r_stk_lo[w_top[SI_W-1:0]];
    assign w_phi  = r_stk_hi[w_top[SI_W-1:0]];
    assign w_plh  = {1'b0, w_plo} + {1'b0, w_phi};
    assign w_pmid = w_plh[POS_W:1];

    // operand reduced below the modulus, one subtract at most
    assign w_v32  = 32'(i_req.value);
    assign w_vred = (w_v32 >= MOD_P) ? VAL_W'(w_v32 - MOD_P) : i_req.value;

    assign w_cfg32 = 32'(i_cfg.length_in_use);
    assign w_len32 = (w_cfg32 == 32'd0) ? 32'd1 :
                     (w_cfg32 > 32'(MAX_ELEMENTS)) ? 32'(MAX_ELEMENTS) : w_cfg32;

    assign w_csum = add_mod(r_ws, w_right_ok ? w_rd_sum : '0);

    assign w_out_load = (r_state == S_FINISH) && (r_op == OP_QUERY) &&
                        (!r_out_valid || o_resp.ready);

    assign i_cfg.ready     = 1'b1;
    assign i_req.ready     = (r_state == S_IDLE);
    assign o_resp.valid    = r_out_valid;
    assign o_resp.range_sum = r_out_sum;

    rast_ram #(.WIDTH(VAL_W), .DEPTH(TN)) u_sum_ram (
        .i_clk  (i_clk),
        .i_we   (w_we_sum),
        .i_waddr(w_waddr),
        .i_wdata(w_wd_sum),
        .i_raddr(w_raddr),
        .o_rdata(w_rd_sum)
    );

    rast_ram #(.WIDTH(VAL_W), .DEPTH(TN)) u_scale_ram (
        .i_clk  (i_clk),
        .i_we   (w_we_tag),
        .i_waddr(w_waddr),
        .i_wdata(w_wd_scale),
        .i_raddr(w_raddr),
        .o_rdata(w_rd_scale)
    );

    rast_ram #(.WIDTH(VAL_W), .DEPTH(TN)) u_offset_ram (
        .i_clk  (i_clk),
        .i_we   (w_we_tag),
        .i_waddr(w_waddr),
        .i_wdata(w_wd_off),
        .i_raddr(w_raddr),
        .o_rdata(w_rd_off)
    );

    rast_mulmod u_mulmod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_mm_req),
        .o_rsp  (w_mm_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:   if (r_clr == AW'(TN - 1)) n_state = S_IDLE;
            S_IDLE:    if (w_accept) n_state = S_VISIT;
            S_VISIT:   n_state = (w_absent || w_disj) ? S_RET : S_NODE;
            S_NODE: begin
                if (w_cover) begin
                    n_state = (r_op == OP_QUERY) ? S_RET : S_AP_RD;
                end else if (w_ident) begin
                    n_state = S_DOWN;
                end else begin
                    n_state = w_left_ok ? S_AP_RD : S_PUSH_R;
                end
            end
            S_AP_RD:   n_state = S_AP_LD;
            S_AP_LD:   n_state = S_AP_GO;
            S_AP_GO:   n_state = S_AP_WAIT;
            S_AP_WAIT: begin
                if (w_mm_rsp.done) begin
                    unique case (r_step)
                        AP_SUM:    n_state = w_leaf ? S_AP_WR : S_AP_GO;
                        AP_OFFSET: n_state = S_AP_WR;
                        default:   n_state = S_AP_GO;
                    endcase
                end
            end
            S_AP_WR: begin
                unique case (r_kind)
                    AK_COVER: n_state = S_RET;
                    AK_LEFT:  n_state = S_PUSH_R;
                    default:  n_state = S_TAGCLR;
                endcase
            end
            S_PUSH_R:  n_state = w_right_ok ? S_AP_RD : S_TAGCLR;
            S_TAGCLR:  n_state = S_DOWN;
            S_DOWN:    n_state = S_VISIT;
            S_RET: begin
                if (r_sp == '0) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = r_node[0] ? S_CB_RDL : S_VISIT;
                end
            end
            S_CB_RDL:  n_state = S_CB_RDR;
            S_CB_RDR:  n_state = S_CB_SUM;
            S_CB_SUM:  n_state = S_RET;
            S_FINISH: begin
                if (r_op != OP_QUERY || !r_out_valid || o_resp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // RAM and multiplier control
    always_comb begin
        w_raddr    = r_node[AW-1:0];
        w_waddr    = r_node[AW-1:0];
        w_we_sum   = 1'b0;
        w_we_tag   = 1'b0;
        w_wd_sum   = r_ws;
        w_wd_scale = r_wsc;
        w_wd_off   = r_wof;
        unique case (r_state)
            S_CLEAR: begin
                w_waddr    = r_clr;
                w_we_sum   = 1'b1;
                w_we_tag   = 1'b1;
                w_wd_sum   = '0;
                w_wd_scale = 30'd1;
                w_wd_off   = '0;
            end
            S_AP_RD:  w_raddr = r_tnode[AW-1:0];
            S_AP_WR: begin
                w_waddr  = r_tnode[AW-1:0];
                w_we_sum = 1'b1;
                w_we_tag = !w_leaf;
            end
            S_TAGCLR: begin
                w_we_tag   = 1'b1;
                w_wd_scale = 30'd1;
                w_wd_off   = '0;
            end
            S_CB_RDL: w_raddr = w_left[AW-1:0];
            S_CB_RDR: w_raddr = w_right[AW-1:0];
            S_CB_SUM: begin
                w_we_sum = 1'b1;
                w_wd_sum = w_csum;
            end
            default: begin
                w_raddr = r_node[AW-1:0];
            end
        endcase

        w_mm_req.start = (r_state == S_AP_GO);
        unique case (r_step)
            AP_LEN: begin
                w_mm_req.x = r_cb;
                w_mm_req.y = VAL_W'(w_tlen);
                w_mm_req.z = '0;
            end
            AP_SUM: begin
                w_mm_req.x = r_ws;
                w_mm_req.y = r_ca;
                w_mm_req.z = r_tmp;
            end
            AP_SCALE: begin
                w_mm_req.x = r_wsc;
                w_mm_req.y = r_ca;
                w_mm_req.z = '0;
            end
            default: begin
                w_mm_req.x = r_wof;
                w_mm_req.y = r_ca;
                w_mm_req.z = r_cb;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sp        <= '0;
            r_clr       <= '0;
            r_len       <= POS_W'(MAX_ELEMENTS);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg.valid) begin
                r_len <= w_len32[POS_W-1:0];
            end
            // push on descent, pop when the right child is done
            if (w_accept) begin
                r_sp <= '0;
            end else if (r_state == S_DOWN) begin
                r_sp <= r_sp + 1'b1;
            end else if (r_state == S_RET && r_sp != '0 && r_node[0]) begin
                r_sp <= r_sp - 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_resp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk datapath
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_sum <= r_acc;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_op   <= t_opcode'(i_req.opcode);
                    r_s    <= CW'(i_req.left);
                    r_f    <= CW'(i_req.right);
                    r_node <= NODE_W'(1);
                    r_lo   <= POS_W'(1);
                    r_hi   <= r_len;
                    r_acc  <= '0;
                    unique case (t_opcode'(i_req.opcode))
                        OP_ADD: begin
                            r_opa <= 30'd1;
                            r_opb <= w_vred;
                        end
                        OP_MUL: begin
                            r_opa <= w_vred;
                            r_opb <= '0;
                        end
                        OP_SET: begin
                            r_opa <= '0;
                            r_opb <= w_vred;
                        end
                        default: begin
                            r_opa <= 30'd1;
                            r_opb <= '0;
                        end
                    endcase
                end
            end
            S_NODE: begin
                if (w_cover) begin
                    if (r_op == OP_QUERY) begin
                        r_acc <= add_mod(r_acc, w_rd_sum);
                    end else begin
                        r_kind  <= AK_COVER;
                        r_tnode <= r_node;
                        r_tlo   <= r_lo;
                        r_thi   <= r_hi;
                        r_ca    <= r_opa;
                        r_cb    <= r_opb;
                    end
                end else begin
                    // push the pending tag into the left child first
                    r_kind  <= AK_LEFT;
                    r_tnode <= w_left;
                    r_tlo   <= r_lo;
                    r_thi   <= w_mid;
                    r_ca    <= w_rd_scale;
                    r_cb    <= w_rd_off;
                end
            end
            S_PUSH_R: begin
                r_kind  <= AK_RIGHT;
                r_tnode <= w_right;
                r_tlo   <= w_mid + 1'b1;
                r_thi   <= r_hi;
            end
            S_AP_LD: begin
                r_ws   <= w_rd_sum;
                r_wsc  <= w_rd_scale;
                r_wof  <= w_rd_off;
                r_step <= AP_LEN;
            end
            S_AP_WAIT: begin
                if (w_mm_rsp.done) begin
                    unique case (r_step)
                        AP_LEN: begin
                            r_tmp  <= w_mm_rsp.res;
                            r_step <= AP_SUM;
                        end
                        AP_SUM: begin
                            r_ws   <= w_mm_rsp.res;
                            r_step <= AP_SCALE;
                        end
                        AP_SCALE: begin
                            r_wsc  <= w_mm_rsp.res;
                            r_step <= AP_OFFSET;
                        end
                        default: begin
                            r_wof  <= w_mm_rsp.res;
                        end
                    endcase
                end
            end
            S_DOWN: begin
                r_stk_lo[r_sp[SI_W-1:0]] <= r_lo;
                r_stk_hi[r_sp[SI_W-1:0]] <= r_hi;
                r_node <= w_left;
                r_hi   <= w_mid;
            end
            S_RET: begin
                if (r_sp != '0) begin
                    if (!r_node[0]) begin
                        // left child finished: move to its sibling
                        r_node <= r_node + 1'b1;
                        r_lo   <= w_pmid + 1'b1;
                        r_hi   <= w_phi;
                    end else begin
                        // right child finished: back up to the parent
                        r_node <= r_node >> 1;
                        r_lo   <= w_plo;
                        r_hi   <= w_phi;
                    end
                end
            end
            S_CB_RDR: begin
                r_ws <= w_left_ok ? w_rd_sum : '0;
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RET || r_state == S_FINISH) |-> ({2'b00, r_acc} < MOD_P))
        else $error("query accumulator left the residue range");

    a_stack_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DOWN) |-> (r_sp < SP_W'(STK_D)))
        else $error("walk stack overflow");

    a_mm_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mm_rsp.done |-> (r_state == S_AP_WAIT))
        else $error("multiply-add finished while the sequencer was not waiting");

    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VISIT) |-> (r_lo <= r_hi))
        else $error("visited node with an empty span");

    a_walk_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |-> (r_sp == '0))
        else $error("walk ended with frames still on the stack");
`endif

endmodule

// File: tb/tb_range_affine_sum_tree_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_range_affine_sum_tree_unit
// Self-checking bench for the range affine sum tree: directed and random
// add, multiply, set and sum requests over several array lengths, each query
// sum compared with a lazy segment tree kept alongside the block.
// ----------------------------------------------------------------------------
module tb_range_affine_sum_tree_unit;
    import rast_pkg::*;

    localparam int unsigned      ELEMS      = DEF_MAX_ELEMENTS;
    localparam int unsigned      NODES      = 2 * ELEMS;
    localparam longint unsigned  PRIME      = 64'd1000000007;
    localparam int unsigned      SETTLE     = 20000;     // longest update walk, generous
    localparam longint unsigned  CYCLE_CAP  = 80000000;
    localparam int unsigned      RANDOM_REQ = 1600;

    // ------------------------------------------------------------------------
    // Lazy segment tree mirror and store of awaited query sums
    // ------------------------------------------------------------------------
    class range_sum_scoreboard;
        bit [VAL_W-1:0]  tree_sum   [NODES];
        bit [VAL_W-1:0]  tree_scale [NODES];
        bit [VAL_W-1:0]  tree_offset[NODES];
        int unsigned     span;
        bit [VAL_W-1:0]  awaited_sums[$];
        int unsigned     mismatches;
        int unsigned     sums_checked;
        int unsigned     requests_seen;

        function void clear_store();
            for (int i = 0; i < NODES; i++) begin
                tree_sum[i]    = '0;
                tree_scale[i]  = VAL_W'(1);
                tree_offset[i] = '0;
            end
            span = ELEMS;
        endfunction

        function void set_span(bit [POS_IN_W-1:0] wr);
            int unsigned v;
            v = wr;
            if (v < 1) v = 1;
            if (v > ELEMS) v = ELEMS;
            span = v;
        endfunction

        function void tag_node(int unsigned node, int unsigned lo, int unsigned hi,
                               longint unsigned a, longint unsigned b);
            longint unsigned width;
            if (node >= NODES) return;
            width = hi - lo + 1;
            tree_sum[node] = VAL_W'((tree_sum[node] * a + (b * width) % PRIME) % PRIME);
            if (lo < hi) begin
                tree_scale[node]  = VAL_W'((tree_scale[node] * a) % PRIME);
                tree_offset[node] = VAL_W'((tree_offset[node] * a + b) % PRIME);
            end
        endfunction

        function void push_tag(int unsigned node, int unsigned lo, int unsigned hi);
            longint unsigned a, b;
            int unsigned mid;
            if (node >= NODES || lo >= hi) return;
            a = tree_scale[node];
            b = tree_offset[node];
            if (a == 1 && b == 0) return;
            mid = (lo + hi) / 2;
            tag_node(2 * node, lo, mid, a, b);
            tag_node(2 * node + 1, mid + 1, hi, a, b);
            tree_scale[node]  = VAL_W'(1);
            tree_offset[node] = '0;
        endfunction

        function longint unsigned descend(int unsigned node, int unsigned lo,
                                          int unsigned hi, int unsigned s,
                                          int unsigned f, bit is_query,
                                          longint unsigned a, longint unsigned b);
            int unsigned mid;
            longint unsigned got, ls, rs;
            if (node >= NODES) return 0;
            if (f < lo || hi < s) return 0;
            if (s <= lo && hi <= f) begin
                if (is_query) return tree_sum[node];
                tag_node(node, lo, hi, a, b);
                return 0;
            end
            push_tag(node, lo, hi);
            mid = (lo + hi) / 2;
            got = (descend(2 * node, lo, mid, s, f, is_query, a, b) +
                   descend(2 * node + 1, mid + 1, hi, s, f, is_query, a, b)) % PRIME;
            ls = (2 * node < NODES) ? tree_sum[2 * node] : 0;
            rs = (2 * node + 1 < NODES) ? tree_sum[2 * node + 1] : 0;
            tree_sum[node] = VAL_W'((ls + rs) % PRIME);
            return got;
        endfunction

        // Note an accepted request; queue its sum when it is a query.
        function void note_request(t_opcode op, bit [POS_IN_W-1:0] l,
                                   bit [POS_IN_W-1:0] r, bit [VAL_W-1:0] v);
            longint unsigned operand;
            operand = longint'(v) % PRIME;
            requests_seen++;
            case (op)
                OP_QUERY: awaited_sums.insert(awaited_sums.size(),
                              VAL_W'(descend(1, 1, span, l, r, 1'b1, 1, 0)));
                OP_ADD:   void'(descend(1, 1, span, l, r, 1'b0, 1, operand));
                OP_MUL:   void'(descend(1, 1, span, l, r, 1'b0, operand, 0));
                default:  void'(descend(1, 1, span, l, r, 1'b0, 0, operand));
            endcase
        endfunction

        function void check_sum(bit [VAL_W-1:0] got);
            bit [VAL_W-1:0] want;
            if (awaited_sums.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected range sum %0d", got);
                return;
            end
            want = awaited_sums.pop_front();
            sums_checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: range sum #%0d expected %0d got %0d",
                             sums_checked, want, got);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    rast_cfg_if cfg_ch ();
    rast_req_if req_ch ();
    rast_rsp_if rsp_ch ();

    range_affine_sum_tree_unit #(.MAX_ELEMENTS(ELEMS)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch.sink),
        .i_req   (req_ch.sink),
        .o_resp  (rsp_ch.source)
    );

    range_sum_scoreboard sb = new();
    bit                  steady_flow;     // suppress all idling in this phase
    longint unsigned     cycle_count;
    int unsigned         length_writes;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // End the run as failed once the total cycle count passes CYCLE_CAP.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("ERROR: timed out after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Response side: random back-pressure driven at the falling edge
    // ------------------------------------------------------------------------
    initial begin
        int unsigned stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                rsp_ch.ready = 1'b0;
            end else if (stall_left > 0) begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready = 1'b1;
                if ($urandom_range(0, 5) == 0) stall_left = pick_gap();
            end
        end
    end

    // Check each sum the moment it is claimed.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) sb.check_sum(rsp_ch.range_sum);
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Called at a falling edge; returns at a falling edge with valid still high
    // so that a back-to-back request keeps the channel busy.
    task automatic send_request(t_opcode op, bit [POS_IN_W-1:0] l,
                                bit [POS_IN_W-1:0] r, bit [VAL_W-1:0] v);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid  = 1'b1;
        req_ch.opcode = op;
        req_ch.left   = l;
        req_ch.right  = r;
        req_ch.value  = v;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(op, l, r, v);
        @(negedge i_clk);
    endtask

    // Wait for every awaited sum, then let any update walk run out.
    task automatic drain();
        req_ch.valid = 1'b0;
        while (sb.awaited_sums.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_length(bit [POS_IN_W-1:0] len);
        cfg_ch.valid         = 1'b1;
        cfg_ch.length_in_use = len;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.set_span(len);
        length_writes++;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Random request: mostly well-formed ranges inside the array, some partly
    // outside or reversed, values now and then left unreduced.
    task automatic random_request();
        t_opcode          op;
        bit [POS_IN_W-1:0] l, r, t;
        bit [VAL_W-1:0]   v;
        int unsigned      pick, n;
        n    = sb.span;
        op   = t_opcode'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            l = POS_IN_W'($urandom_range(1, n));
            r = POS_IN_W'(l + $urandom_range(0, 7));
            if (r > n) r = POS_IN_W'(n);
        end else if (pick < 80) begin
            l = POS_IN_W'($urandom_range(1, n));
            r = POS_IN_W'($urandom_range(1, n));
            if (l > r) begin
                t = l; l = r; r = t;
            end
        end else if (pick < 95) begin
            l = POS_IN_W'($urandom_range(0, 2047));
            r = POS_IN_W'($urandom_range(0, 2047));
        end else begin
            l = POS_IN_W'($urandom_range(1, n));
            r = POS_IN_W'(l - $urandom_range(1, 4));
        end
        if ($urandom_range(0, 9) == 0) v = VAL_W'($urandom);
        else v = VAL_W'($urandom_range(0, 1000000006));
        send_request(op, l, r, v);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        bit [POS_IN_W-1:0] phase_len [7] = '{11'd8, 11'd0, 11'd2047, 11'd37,
                                             11'd1, 11'd1024, 11'd300};
        cycle_count          = 0;
        length_writes        = 0;
        steady_flow          = 1'b0;
        sb.clear_store();
        i_rst_n              = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.length_in_use = '0;
        req_ch.valid         = 1'b0;
        req_ch.opcode        = OP_ADD;
        req_ch.left          = '0;
        req_ch.right         = '0;
        req_ch.value         = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part over the reset length: extremes, every operation,
        // unreduced values, ranges partly outside and reversed ranges.
        send_request(OP_SET,   11'd1,    11'd1024, 30'd1000000006);
        send_request(OP_QUERY, 11'd1,    11'd1024, 30'd0);
        send_request(OP_ADD,   11'd1,    11'd1,    30'd0);
        send_request(OP_MUL,   11'd500,  11'd600,  30'd1000000006);
        send_request(OP_SET,   11'd3,    11'd3,    30'h3FFFFFFF);
        send_request(OP_QUERY, 11'd3,    11'd3,    30'h3FFFFFFF);
        send_request(OP_ADD,   11'd1,    11'd1024, 30'd1000000007);
        send_request(OP_QUERY, 11'd0,    11'd2047, 30'd0);
        send_request(OP_QUERY, 11'd10,   11'd5,    30'd0);
        send_request(OP_ADD,   11'd10,   11'd5,    30'd77);
        send_request(OP_ADD,   11'd1024, 11'd2047, 30'd12345);
        send_request(OP_MUL,   11'd5,    11'd5,    30'd0);
        send_request(OP_QUERY, 11'd1,    11'd1,    30'd0);
        send_request(OP_QUERY, 11'd1024, 11'd1024, 30'd0);
        send_request(OP_ADD,   11'd0,    11'd0,    30'd9);
        send_request(OP_QUERY, 11'd0,    11'd0,    30'd0);
        send_request(OP_MUL,   11'd1,    11'd512,  30'd2);
        send_request(OP_QUERY, 11'd256,  11'd768,  30'd0);
        send_request(OP_QUERY, 11'd1,    11'd1024, 30'd0);
        drain();

        // Random phases, each under its own length; the store carries over.
        foreach (phase_len[p]) begin
            write_length(phase_len[p]);
            steady_flow = (p == 5);
            repeat (RANDOM_REQ / 7) random_request();
            send_request(OP_QUERY, 11'd1, 11'd1024, 30'd0);
            drain();
        end

        $display("Covered %0d requests, %0d query sums checked, %0d length writes.",
                 sb.requests_seen, sb.sums_checked, length_writes);
        $display("Lengths 1 to 1024 incl. clamped writes; idling on both channels.");
        if (sb.mismatches == 0 && sb.awaited_sums.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("ERROR: %0d mismatches, %0d sums never arrived",
                     sb.mismatches, sb.awaited_sums.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
